[src/pidis_pkg.sv]
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes, reset values and the configuration struct shared
// by the PID controller with integral separation.
// ----------------------------------------------------------------------------
package pidis_pkg;

    localparam int GAIN_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int ERR_W      = 17;
    localparam int BAND_W     = 17;
    localparam int LIMIT_W    = 31;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_BAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd5;

    // reset values
    localparam logic [BAND_W-1:0]  BAND_RST  = 17'h1FFFF;
    localparam logic [LIMIT_W-1:0] ILIM_RST  = 31'h7FFFFFFF;
    localparam logic [LIMIT_W-1:0] OLIM_RST  = 31'h0;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [DATA_W-1:0]   t_word;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [BAND_W-1:0]        integral_band;
        logic [LIMIT_W-1:0]       integral_limit;
        logic [LIMIT_W-1:0]       output_limit;
    } t_cfg;

endpackage

[src/pidis_in_if.sv]
// ----------------------------------------------------------------------------
// PID sample channel
// Valid/ready channel carrying one setpoint and measured value per request.
// ----------------------------------------------------------------------------
interface pidis_in_if;
    import pidis_pkg::*;

    logic    valid;
    logic    ready;
    t_sample setpoint;
    t_sample measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink   (input valid, input setpoint, input measured, output ready);

endinterface

[src/pidis_out_if.sv]
// ----------------------------------------------------------------------------
// PID result channel
// Valid/ready channel carrying the clamped drive and the integral per request.
// ----------------------------------------------------------------------------
interface pidis_out_if;
    import pidis_pkg::*;

    logic  valid;
    logic  ready;
    t_word drive;
    t_word integral_term;

    modport source (output valid, output drive, output integral_term, input ready);
    modport sink   (input valid, input drive, input integral_term, output ready);

endinterface

[src/pid_with_integral_separation.sv]
// ----------------------------------------------------------------------------
// PID controller with integral separation
// Positional PID: P, clamped and band-gated I, D on error difference, clamped
// drive. Three-stage pipeline: sample register, gain products, integral/sum.
// ----------------------------------------------------------------------------
// Takes one setpoint/measured request per clock cycle while the result side
// accepts, and returns one result per request, in order. A result passes the
// sample, product and output registers. The integral update, total sum and
// both clamps close in a single stage, so throughput holds at one request per
// cycle with the integral feedback intact unless the output stalls. Gains are
// signed Q8.8 (GAIN_FRAC_BITS fraction bits); products are truncated toward
// zero. Configuration must be written while no request is in flight.
module pid_with_integral_separation #(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pidis_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pidis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pidis_in_if.sink                         i_in,
    pidis_out_if.source                      o_out
);
    import pidis_pkg::*;

    localparam int PROD_W = 34;   // widest product: 16b gain x 18b error step
    localparam int SUM_W  = 36;
    localparam logic signed [PROD_W-1:0] BIAS =
        PROD_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    // truncating shift toward zero
    function automatic logic signed [PROD_W-1:0] scale_gain(
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [PROD_W-1:0] biased;
        biased = prod[PROD_W-1] ? prod + BIAS : prod;
        return biased >>> GAIN_FRAC_BITS;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_sym(
        input logic signed [SUM_W-1:0] v,
        input logic [LIMIT_W-1:0]      lim
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed({{(SUM_W-LIMIT_W){1'b0}}, lim});
        lo = -hi;
        if (v > hi) return hi[DATA_W-1:0];
        else if (v < lo) return lo[DATA_W-1:0];
        else return v[DATA_W-1:0];
    endfunction

    t_cfg w_cfg;

    pidis_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // flow control: each stage loads when its downstream slot frees up
    logic w_out_free, w_s2_free, w_s1_free;

    logic    r_s1_v;
    t_sample r_s1_sp, r_s1_ms;

    logic                       r_s2_v;
    logic                       r_s2_band;
    logic signed [PROD_W-2:0]   r_s2_p;
    logic signed [PROD_W-2:0]   r_s2_i;
    logic signed [PROD_W-1:0]   r_s2_d;

    logic signed [ERR_W-1:0]    r_prev_err;
    t_word                      r_acc;

    logic  r_out_v;
    t_word r_out_drive;
    t_word r_out_integ;

    assign w_out_free = !r_out_v || o_out.ready;
    assign w_s2_free  = !r_s2_v || w_out_free;
    assign w_s1_free  = !r_s1_v || w_s2_free;
    assign i_in.ready = w_s1_free;

    // stage 1: error, band check, gain products
    logic signed [ERR_W-1:0]  w_err;
    logic [ERR_W-1:0]         w_mag;
    logic signed [ERR_W:0]    w_diff;
    logic signed [PROD_W-2:0] w_p_prod;
    logic signed [PROD_W-2:0] w_i_prod;
    logic signed [PROD_W-1:0] w_d_prod;
    logic signed [PROD_W-1:0] n_p, n_i, n_d;
    logic                     n_band;

    always_comb begin
        w_err    = ERR_W'(r_s1_sp) - ERR_W'(r_s1_ms);
        w_mag    = w_err[ERR_W-1] ? ERR_W'(-w_err) : ERR_W'(w_err);
        w_diff   = (ERR_W+1)'(w_err) - (ERR_W+1)'(r_prev_err);
        w_p_prod = w_cfg.gain_p * w_err;
        w_i_prod = w_cfg.gain_i * w_err;
        w_d_prod = w_cfg.gain_d * w_diff;
        n_p      = scale_gain(PROD_W'(w_p_prod));
        n_i      = scale_gain(PROD_W'(w_i_prod));
        n_d      = scale_gain(w_d_prod);
        n_band   = w_mag < w_cfg.integral_band;
    end

    // stage 2: integral update, total, drive clamp
    logic signed [PROD_W-1:0] w_acc_sum;
    t_word                    n_acc;
    logic signed [SUM_W-1:0]  w_total;
    t_word                    n_drive;

    always_comb begin
        w_acc_sum = PROD_W'(r_acc) + PROD_W'(r_s2_i);
        n_acc     = r_s2_band ? clamp_sym(SUM_W'(w_acc_sum), w_cfg.integral_limit)
                              : '0;
        w_total   = SUM_W'(r_s2_p) + SUM_W'(n_acc) + SUM_W'(r_s2_d);
        n_drive   = clamp_sym(w_total, w_cfg.output_limit);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_prev_err <= '0;
            r_acc      <= '0;
        end else begin
            if (w_s1_free) r_s1_v <= i_in.valid;
            if (w_s2_free) r_s2_v <= r_s1_v;
            if (w_out_free) r_out_v <= r_s2_v;
            if (w_s2_free && r_s1_v) r_prev_err <= w_err;
            if (w_out_free && r_s2_v) r_acc <= n_acc;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_in.valid) begin
            r_s1_sp <= i_in.setpoint;
            r_s1_ms <= i_in.measured;
        end
        if (w_s2_free && r_s1_v) begin
            r_s2_p    <= n_p[PROD_W-2:0];
            r_s2_i    <= n_i[PROD_W-2:0];
            r_s2_d    <= n_d;
            r_s2_band <= n_band;
        end
        if (w_out_free && r_s2_v) begin
            r_out_drive <= n_drive;
            r_out_integ <= n_acc;
        end
    end

    assign o_out.valid         = r_out_v;
    assign o_out.drive         = r_out_drive;
    assign o_out.integral_term = r_out_integ;

    // symmetric clamps never produce the most negative word
    a_acc_not_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc != {1'b1, {(DATA_W-1){1'b0}}})
        else $error("integral reached most negative value");

    a_drive_not_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> r_out_drive != {1'b1, {(DATA_W-1){1'b0}}})
        else $error("drive reached most negative value");

    a_acc_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && !w_out_free) |=> $stable(r_acc))
        else $error("integral changed while result stalled");

    a_out_band_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && w_out_free && !r_s2_band) |=> (r_acc == '0 && r_out_integ == '0))
        else $error("integral not cleared outside band");

    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_v && !w_out_free) |=> r_s2_v)
        else $error("stage 2 request dropped under stall");

endmodule

[src/pidis_cfg_regs.sv]
// ----------------------------------------------------------------------------
// PID configuration registers
// Write-only register file for gains, integral band and clamp limits.
// ----------------------------------------------------------------------------
module pidis_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pidis_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pidis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output pidis_pkg::t_cfg                  o_cfg
);
    import pidis_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.integral_band  <= BAND_RST;
            r_cfg.integral_limit <= ILIM_RST;
            r_cfg.output_limit   <= OLIM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN_P:         r_cfg.gain_p         <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:         r_cfg.gain_i         <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:         r_cfg.gain_d         <= i_cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_BAND:  r_cfg.integral_band  <= i_cfg_data[BAND_W-1:0];
                REG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_OUTPUT_LIMIT:   r_cfg.output_limit   <= i_cfg_data[LIMIT_W-1:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[tb/sv/pid_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID result checker
// Follows register writes and sample requests, computes the expected drive and
// integral for each request, and compares every returned result against the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module pid_result_checker #(
    parameter int FRAC_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pidis_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pidis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pidis_in_if                              i_smp,
    pidis_out_if                             i_res,
    output int                               o_pending,
    output int                               o_fail_count
);
    import pidis_pkg::*;

    typedef struct packed {
        t_word drive;
        t_word integral_term;
    } t_pid_result;

    t_pid_result result_q[$];
    t_cfg        cfg;
    longint      integ_acc;
    longint      prev_err;
    int          fails = 0;

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Q8.8 product, truncated toward zero
    function automatic longint gain_product(input logic signed [GAIN_W-1:0] g,
                                            input longint x);
        return (longint'(g) * x) / (longint'(1) << FRAC_BITS);
    endfunction

    // one controller step: updates integral and previous error
    function automatic t_pid_result pid_step(input t_sample sp, input t_sample ms);
        longint      err;
        longint      mag;
        longint      p_term;
        longint      d_term;
        longint      total;
        t_pid_result r;
        err    = longint'(sp) - longint'(ms);
        mag    = (err < 0) ? -err : err;
        p_term = gain_product(cfg.gain_p, err);
        d_term = gain_product(cfg.gain_d, err - prev_err);
        if (mag < longint'(cfg.integral_band))
            integ_acc = clamp_sym(integ_acc + gain_product(cfg.gain_i, err),
                                  longint'(cfg.integral_limit));
        else
            integ_acc = 0;
        total    = clamp_sym(p_term + integ_acc + d_term, longint'(cfg.output_limit));
        prev_err = err;
        r.drive         = total[DATA_W-1:0];
        r.integral_term = integ_acc[DATA_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_pid_result exp_r;
        if (!i_rst_n) begin
            cfg.gain_p         = '0;
            cfg.gain_i         = '0;
            cfg.gain_d         = '0;
            cfg.integral_band  = BAND_RST;
            cfg.integral_limit = ILIM_RST;
            cfg.output_limit   = OLIM_RST;
            integ_acc          = 0;
            prev_err           = 0;
            result_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GAIN_P:         cfg.gain_p         = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_I:         cfg.gain_i         = i_cfg_data[GAIN_W-1:0];
                    REG_GAIN_D:         cfg.gain_d         = i_cfg_data[GAIN_W-1:0];
                    REG_INTEGRAL_BAND:  cfg.integral_band  = i_cfg_data[BAND_W-1:0];
                    REG_INTEGRAL_LIMIT: cfg.integral_limit = i_cfg_data[LIMIT_W-1:0];
                    REG_OUTPUT_LIMIT:   cfg.output_limit   = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_smp.valid && i_smp.ready)
                result_q.push_back(pid_step(i_smp.setpoint, i_smp.measured));
            if (i_res.valid && i_res.ready) begin
                if (result_q.size() == 0) begin
                    fails++;
                    $error("result with no request outstanding: drive %0d, integral_term %0d",
                           i_res.drive, i_res.integral_term);
                end else begin
                    exp_r = result_q.pop_front();
                    if (i_res.drive !== exp_r.drive) begin
                        fails++;
                        $error("drive mismatch: expected %0d, actual %0d",
                               exp_r.drive, i_res.drive);
                    end
                    if (i_res.integral_term !== exp_r.integral_term) begin
                        fails++;
                        $error("integral_term mismatch: expected %0d, actual %0d",
                               exp_r.integral_term, i_res.integral_term);
                    end
                end
            end
        end
        o_pending    <= result_q.size();
        o_fail_count <= fails;
    end

endmodule

[tb/sv/tb_pid_with_integral_separation.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PID controller with integral separation testbench
// Directed corner requests under several register settings, then random
// phases with fresh settings and mixed error profiles. Both channels idle at
// random; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_pid_with_integral_separation;
    import pidis_pkg::*;

    localparam int FRAC_BITS      = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RAND_PHASES    = 9;
    localparam int PHASE_ITEMS    = 92;

    // indexes past the register list; writes there must have no effect
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [GAIN_W-1:0] GAIN_MAX  = 16'sh7FFF;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN  = 16'sh8000;
    localparam logic [BAND_W-1:0]        BAND_MAX  = '1;
    localparam logic [LIMIT_W-1:0]       LIMIT_MAX = '1;
    localparam t_sample                  SMP_MAX   = 16'sh7FFF;
    localparam t_sample                  SMP_MIN   = 16'sh8000;

    typedef enum int {
        MODE_UNIFORM,
        MODE_NEAR,
        MODE_HOLD,
        MODE_CORNER
    } t_mode;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    fail_count;
    int                    idle_cycles = 0;
    bit                    calm = 1'b0;

    pidis_in_if  smp_if ();
    pidis_out_if res_if ();

    always #5 clk = ~clk;

    pid_with_integral_separation #(
        .GAIN_FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (smp_if),
        .o_out     (res_if)
    );

    pid_result_checker #(
        .FRAC_BITS(FRAC_BITS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_smp       (smp_if),
        .i_res       (res_if),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    // mostly short gaps, a few long ones; none while calm
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_sample pick_corner_sample();
        case ($urandom_range(0, 3))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    function automatic logic signed [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return GAIN_MAX;
            1:       return GAIN_MIN;
            2:       return 16'sd0;
            3:       return 16'sd256;
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return LIMIT_MAX;
            2:       return LIMIT_W'($urandom_range(1, 100000));
            3:       return LIMIT_W'($urandom_range(1, 50000000));
            default: return LIMIT_W'($urandom);
        endcase
    endfunction

    // valid stays high across back-to-back requests
    task automatic send_sample(input t_sample sp, input t_sample ms);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            smp_if.valid    <= 1'b0;
            smp_if.setpoint <= t_sample'($urandom);
            smp_if.measured <= t_sample'($urandom);
            repeat (gap) @(posedge clk);
        end
        smp_if.valid    <= 1'b1;
        smp_if.setpoint <= sp;
        smp_if.measured <= ms;
        do @(posedge clk); while (!smp_if.ready);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_cfg(input t_cfg c, input bit spare);
        logic [CFG_IDX_W-1:0]  idx [7];
        logic [CFG_DATA_W-1:0] val [7];
        logic [CFG_DATA_W-1:0] junk;
        int                    n;
        // upper bits above each field are don't-care
        junk   = CFG_DATA_W'($urandom);
        idx[0] = REG_GAIN_P;
        val[0] = {junk[30:16], c.gain_p};
        idx[1] = REG_GAIN_I;
        val[1] = {junk[30:16], c.gain_i};
        idx[2] = REG_GAIN_D;
        val[2] = {junk[30:16], c.gain_d};
        idx[3] = REG_INTEGRAL_BAND;
        val[3] = {junk[30:17], c.integral_band};
        idx[4] = REG_INTEGRAL_LIMIT;
        val[4] = c.integral_limit;
        idx[5] = REG_OUTPUT_LIMIT;
        val[5] = c.output_limit;
        idx[6] = ($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI;
        val[6] = CFG_DATA_W'($urandom);
        n      = spare ? 7 : 6;
        for (int k = 0; k < n; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx[k];
            cfg_data <= val[k];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // result side: random stalls
    initial begin
        int stall;
        int run;
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            run = $urandom_range(1, 8);
            repeat (run) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_cfg    c;
        t_mode   dom;
        t_mode   mode;
        t_sample sp;
        t_sample ms;
        t_sample hold_sp;
        t_sample hold_ms;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= '0;
        cfg_data        <= '0;
        smp_if.valid    <= 1'b0;
        smp_if.setpoint <= '0;
        smp_if.measured <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: output limit zero, drive must stay zero
        send_sample(SMP_MAX, SMP_MIN);
        send_sample(SMP_MIN, SMP_MAX);
        drain();

        // full-scale gains, widest P and D terms, widest error swing
        c = '{GAIN_MAX, GAIN_MAX, GAIN_MIN, BAND_MAX, LIMIT_MAX, LIMIT_MAX};
        write_cfg(c, 1'b0);
        send_sample(SMP_MAX, SMP_MIN);
        send_sample(SMP_MIN, SMP_MAX);
        send_sample(16'sd0, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd0, -16'sd1);
        send_sample(SMP_MAX, SMP_MIN);
        send_sample(SMP_MAX, SMP_MIN);
        drain();

        // band of zero: every error is outside, integral clears
        c = '{GAIN_MIN, GAIN_MIN, GAIN_MAX, 17'd0, 31'd0, 31'd1};
        write_cfg(c, 1'b0);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd100, -16'sd100);
        send_sample(SMP_MIN, SMP_MAX);
        drain();

        // band edge and integral clamp on both signs
        c = '{16'sd256, 16'sd256, 16'sd256, 17'd100, 31'd250, LIMIT_MAX};
        write_cfg(c, 1'b0);
        send_sample(16'sd99, 16'sd0);
        send_sample(16'sd99, 16'sd0);
        send_sample(16'sd99, 16'sd0);
        send_sample(-16'sd99, 16'sd0);
        send_sample(16'sd0, 16'sd100);
        send_sample(-16'sd99, 16'sd0);
        send_sample(-16'sd99, 16'sd0);
        send_sample(-16'sd99, 16'sd0);
        drain();

        // drive clamp on both signs; spare index write must be ignored
        c = '{GAIN_MAX, GAIN_MAX, GAIN_MAX, BAND_MAX, LIMIT_MAX, 31'd1000};
        write_cfg(c, 1'b1);
        send_sample(SMP_MAX, SMP_MIN);
        send_sample(SMP_MIN, SMP_MAX);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            calm     = ($urandom_range(0, 3) == 0);
            c.gain_p = pick_gain();
            c.gain_i = pick_gain();
            c.gain_d = pick_gain();
            case ($urandom_range(0, 4))
                0:       c.integral_band = '0;
                1:       c.integral_band = BAND_MAX;
                2:       c.integral_band = BAND_W'($urandom_range(1, 2000));
                default: c.integral_band = BAND_W'($urandom);
            endcase
            c.integral_limit = pick_limit();
            c.output_limit   = pick_limit();
            write_cfg(c, $urandom_range(0, 3) == 0);
            dom     = t_mode'($urandom_range(0, 3));
            hold_sp = ($urandom_range(0, 1) != 0) ? pick_corner_sample() : t_sample'($urandom);
            hold_ms = ($urandom_range(0, 1) != 0) ? pick_corner_sample() : t_sample'($urandom);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2 && (ph == 0 || $urandom_range(0, 2) == 0))
                    drain();
                mode = ($urandom_range(0, 9) < 7) ? dom : t_mode'($urandom_range(0, 3));
                case (mode)
                    MODE_UNIFORM: begin
                        sp = t_sample'($urandom);
                        ms = t_sample'($urandom);
                    end
                    MODE_NEAR: begin
                        ms = t_sample'($urandom);
                        sp = ms + t_sample'($urandom_range(0, 400)) - 16'sd200;
                    end
                    // steady error drives the integral into its clamp
                    MODE_HOLD: begin
                        sp = hold_sp;
                        ms = hold_ms;
                    end
                    default: begin
                        sp = pick_corner_sample();
                        ms = pick_corner_sample();
                    end
                endcase
                send_sample(sp, ms);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
